[design/rau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// shared types, constants and mode codes of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int WORD_BITS = 32;
    localparam int MODE_BITS = 3;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [MODE_BITS-1:0] mode_t;

    localparam mode_t MODE_ADD  = 3'd0;
    localparam mode_t MODE_SUB  = 3'd1;
    localparam mode_t MODE_MUL  = 3'd2;
    localparam mode_t MODE_DIV  = 3'd3;
    localparam mode_t MODE_INV  = 3'd4;
    localparam mode_t MODE_NORM = 3'd5;

    localparam word_t MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};

    // raw pair handed from front to back
    typedef struct packed {
        word_t n;
        word_t d;
        logic  twice;
    } job_t;
endpackage
`default_nettype wire

[design/rau_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_front
// accepts items and forms the raw numerator and denominator over a few steps
// ----------------------------------------------------------------------------
module rau_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire rau_pkg::mode_t mode,
    input  wire rau_pkg::word_t num_a,
    input  wire rau_pkg::word_t den_a,
    input  wire rau_pkg::word_t num_b,
    input  wire rau_pkg::word_t den_b,
    output logic                job_valid,
    input  wire logic           job_ready,
    output rau_pkg::job_t       job
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M1   = 3'd1;
    localparam logic [2:0] S_M2   = 3'd2;
    localparam logic [2:0] S_M3   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    rau_pkg::mode_t mode_reg;
    rau_pkg::word_t na_reg, da_reg, nb_reg, db_reg;
    rau_pkg::word_t p1_reg, p2_reg, p3_reg;
    rau_pkg::word_t ma, mb, prod;
    rau_pkg::word_t n_c, d_c;
    logic twice_c;

    assign full      = (state_reg != S_IDLE);
    assign job_valid = (state_reg == S_OUT);

    // one multiplier, three products in turn
    always_comb
    begin
        ma = na_reg;
        mb = db_reg;
        case (state_reg)
            S_M1:
            begin
                case (mode_reg)
                    rau_pkg::MODE_MUL: begin ma = na_reg; mb = nb_reg; end
                    default:           begin ma = na_reg; mb = db_reg; end
                endcase
            end
            S_M2:
            begin
                case (mode_reg)
                    rau_pkg::MODE_DIV: begin ma = da_reg; mb = nb_reg; end
                    default:           begin ma = da_reg; mb = db_reg; end
                endcase
            end
            S_M3:    begin ma = nb_reg; mb = da_reg; end
            default: begin ma = na_reg; mb = db_reg; end
        endcase
        prod = rau_pkg::word_t'(ma * mb);
    end

    always_comb
    begin
        twice_c = 1'b1;
        case (mode_reg)
            rau_pkg::MODE_ADD: begin n_c = p1_reg + p3_reg; d_c = p2_reg; end
            rau_pkg::MODE_SUB: begin n_c = p1_reg - p3_reg; d_c = p2_reg; end
            rau_pkg::MODE_MUL: begin n_c = p1_reg; d_c = p2_reg; end
            rau_pkg::MODE_DIV: begin n_c = p1_reg; d_c = p2_reg; end
            rau_pkg::MODE_INV: begin n_c = da_reg; d_c = na_reg; end
            default:           begin n_c = na_reg; d_c = da_reg; twice_c = 1'b0; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (push) state_next = S_M1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_OUT;
            S_OUT:   if (job_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && push)
        begin
            mode_reg <= mode;
            na_reg   <= num_a;
            da_reg   <= den_a;
            nb_reg   <= num_b;
            db_reg   <= den_b;
        end
        if (state_reg == S_M1) p1_reg <= prod;
        if (state_reg == S_M2) p2_reg <= prod;
        if (state_reg == S_M3) p3_reg <= prod;
    end

    assign job.n     = n_c;
    assign job.d     = d_c;
    assign job.twice = twice_c;
endmodule
`default_nettype wire

[design/rau_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module rau_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire rau_pkg::job_t in_job,
    output logic               out_valid,
    input  wire logic          out_ready,
    output rau_pkg::job_t      out_job
);
    rau_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rp_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= in_job;
    end
endmodule
`default_nettype wire

[design/rau_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_back
// builds the fraction and reduces it by euclid with a serial divider
// ----------------------------------------------------------------------------
module rau_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire rau_pkg::job_t  job,
    output logic                empty,
    input  wire logic           pop,
    output rau_pkg::word_t      res_num,
    output rau_pkg::word_t      res_den
);
    localparam int W = rau_pkg::WORD_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIVN = 3'd2;
    localparam logic [2:0] S_DIVD = 3'd3;
    localparam logic [2:0] S_RUN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, ret_reg;
    rau_pkg::word_t n_reg, d_reg, x_reg, y_reg, g_reg;
    logic twice_reg;
    logic out_valid_reg;
    rau_pkg::word_t on_reg, od_reg;

    // serial divider
    logic [W-1:0] q_reg, ma_reg, mb_reg;
    logic [W:0]   r_reg;
    logic [rau_pkg::CNT_BITS-1:0] cnt_reg;
    logic         sa_reg, sb_reg;
    logic [W:0]   r_sh, r_sub;
    logic [W-1:0] quo, rem;

    function automatic logic [W-1:0] absw(input rau_pkg::word_t v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    assign r_sh  = {r_reg[W-1:0], ma_reg[W-1]};
    assign r_sub = r_sh - {1'b0, mb_reg};
    assign quo   = (sa_reg != sb_reg) ? W'(-q_reg) : q_reg;
    assign rem   = sa_reg ? W'(-r_reg[W-1:0]) : r_reg[W-1:0];

    assign job_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign empty     = !out_valid_reg;
    assign res_num   = on_reg;
    assign res_den   = od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (job_valid && !out_valid_reg)
                    begin
                        twice_reg <= job.twice;
                        if (job.d == '0)
                        begin
                            n_reg <= rau_pkg::MAXV;
                            d_reg <= W'(1);
                            x_reg <= rau_pkg::MAXV;
                            y_reg <= W'(1);
                        end
                        else
                        begin
                            n_reg <= job.n;
                            d_reg <= job.d;
                            x_reg <= job.n;
                            y_reg <= job.d;
                        end
                        state_reg <= S_GCD;
                    end
                S_GCD:
                    if (x_reg == '0)
                    begin
                        g_reg <= y_reg;
                        state_reg <= S_DIVN;
                    end
                    else if (y_reg == '0)
                    begin
                        g_reg <= x_reg;
                        state_reg <= S_DIVN;
                    end
                    else
                    begin
                        ma_reg <= absw(x_reg);
                        mb_reg <= absw(y_reg);
                        sa_reg <= x_reg[W-1];
                        sb_reg <= y_reg[W-1];
                        r_reg <= '0;
                        cnt_reg <= '0;
                        ret_reg <= S_GCD;
                        state_reg <= S_RUN;
                    end
                S_DIVN:
                begin
                    ma_reg <= absw(n_reg);
                    mb_reg <= absw(g_reg);
                    sa_reg <= n_reg[W-1];
                    sb_reg <= g_reg[W-1];
                    r_reg <= '0;
                    cnt_reg <= '0;
                    ret_reg <= S_DIVN;
                    state_reg <= S_RUN;
                end
                S_DIVD:
                begin
                    ma_reg <= absw(d_reg);
                    mb_reg <= absw(g_reg);
                    sa_reg <= d_reg[W-1];
                    sb_reg <= g_reg[W-1];
                    r_reg <= '0;
                    cnt_reg <= '0;
                    ret_reg <= S_DIVD;
                    state_reg <= S_RUN;
                end
                S_RUN:
                    if (cnt_reg == rau_pkg::CNT_BITS'(W))
                    begin
                        case (ret_reg)
                            S_GCD:
                            begin
                                x_reg <= y_reg;
                                y_reg <= rem;
                                state_reg <= S_GCD;
                            end
                            S_DIVN:
                            begin
                                n_reg <= quo;
                                state_reg <= S_DIVD;
                            end
                            default:
                            begin
                                if (twice_reg)
                                begin
                                    twice_reg <= 1'b0;
                                    d_reg <= quo;
                                    x_reg <= n_reg;
                                    y_reg <= quo;
                                    state_reg <= S_GCD;
                                end
                                else
                                begin
                                    d_reg <= quo;
                                    state_reg <= S_DONE;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        ma_reg <= {ma_reg[W-2:0], 1'b0};
                        if (!r_sub[W])
                        begin
                            r_reg <= r_sub;
                            q_reg <= {q_reg[W-2:0], 1'b1};
                        end
                        else
                        begin
                            r_reg <= r_sh;
                            q_reg <= {q_reg[W-2:0], 1'b0};
                        end
                    end
                S_DONE:
                begin
                    on_reg <= n_reg;
                    od_reg <= d_reg;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/rational_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// fraction add, subtract, multiply, divide, invert and normalize with gcd
// reduction. The front forms the raw pair with one shared multiplier; the
// back runs euclid on a one-bit-per-cycle divider, which also does the final
// divisions of numerator and denominator by the gcd. One item is worked in
// the back at a time.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire rau_pkg::mode_t mode,
    input  wire rau_pkg::word_t num_a,
    input  wire rau_pkg::word_t den_a,
    input  wire rau_pkg::word_t num_b,
    input  wire rau_pkg::word_t den_b,
    output logic                empty,
    input  wire logic           pop,
    output rau_pkg::word_t      res_num,
    output rau_pkg::word_t      res_den
);
    logic f_valid, f_ready, q_valid, q_ready;
    rau_pkg::job_t f_job, q_job;

    rau_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .mode(mode),
        .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    rau_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_ready(f_ready),
        .in_job(f_job), .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
    );

    rau_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job_ready(q_ready),
        .job(q_job), .empty(empty), .pop(pop), .res_num(res_num), .res_den(res_den)
    );
endmodule
`default_nettype wire

[tb/rau_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker
// watches the operand and result queues of the fraction unit, computes the
// reduced fraction for every accepted operand transfer and compares each
// accepted result against the oldest pending fraction
// ----------------------------------------------------------------------------
module rau_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic           full,
    input  wire rau_pkg::mode_t mode,
    input  wire rau_pkg::word_t num_a,
    input  wire rau_pkg::word_t den_a,
    input  wire rau_pkg::word_t num_b,
    input  wire rau_pkg::word_t den_b,
    input  wire logic           empty,
    input  wire logic           pop,
    input  wire rau_pkg::word_t res_num,
    input  wire rau_pkg::word_t res_den,
    output int                  errors,
    output int                  pending
);
    typedef struct packed {
        rau_pkg::word_t n;
        rau_pkg::word_t d;
    } frac_t;

    frac_t fracq[$];

    function automatic rau_pkg::word_t trunc_quot(rau_pkg::word_t a, rau_pkg::word_t b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned q;
        ma = a[rau_pkg::WORD_BITS-1] ? -longint'(a) : longint'(a);
        mb = b[rau_pkg::WORD_BITS-1] ? -longint'(b) : longint'(b);
        if (mb == 0)
            return '0;
        q = ma / mb;
        if (a[rau_pkg::WORD_BITS-1] != b[rau_pkg::WORD_BITS-1])
            q = -q;
        return rau_pkg::word_t'(q);
    endfunction

    function automatic rau_pkg::word_t trunc_rem(rau_pkg::word_t a, rau_pkg::word_t b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned r;
        ma = a[rau_pkg::WORD_BITS-1] ? -longint'(a) : longint'(a);
        mb = b[rau_pkg::WORD_BITS-1] ? -longint'(b) : longint'(b);
        if (mb == 0)
            return a;
        r = ma % mb;
        if (a[rau_pkg::WORD_BITS-1])
            r = -r;
        return rau_pkg::word_t'(r);
    endfunction

    function automatic frac_t reduce_frac(frac_t f);
        rau_pkg::word_t x;
        rau_pkg::word_t y;
        rau_pkg::word_t r;
        frac_t o;
        x = f.n;
        y = f.d;
        while (x != 0 && y != 0)
        begin
            r = trunc_rem(x, y);
            x = y;
            y = r;
        end
        if (x == 0)
            x = y;
        o.n = trunc_quot(f.n, x);
        o.d = trunc_quot(f.d, x);
        return o;
    endfunction

    function automatic frac_t fraction_of(rau_pkg::mode_t m, rau_pkg::word_t na,
                                          rau_pkg::word_t da, rau_pkg::word_t nb,
                                          rau_pkg::word_t db);
        frac_t f;
        logic twice;
        twice = 1'b1;
        case (m)
            rau_pkg::MODE_ADD: begin f.n = na * db + nb * da; f.d = da * db; end
            rau_pkg::MODE_SUB: begin f.n = na * db - nb * da; f.d = da * db; end
            rau_pkg::MODE_MUL: begin f.n = na * nb; f.d = da * db; end
            rau_pkg::MODE_DIV: begin f.n = na * db; f.d = da * nb; end
            rau_pkg::MODE_INV: begin f.n = da; f.d = na; end
            default:           begin f.n = na; f.d = da; twice = 1'b0; end
        endcase
        if (f.d == 0)
        begin
            f.n = rau_pkg::MAXV;
            f.d = 1;
        end
        f = reduce_frac(f);
        if (twice)
            f = reduce_frac(f);
        return f;
    endfunction

    task automatic report(string what, rau_pkg::word_t got, rau_pkg::word_t want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    assign pending = fracq.size();

    always @(posedge clk)
    begin
        frac_t w;
        if (rst_n)
        begin
            if (push && !full)
                fracq.push_back(fraction_of(mode, num_a, den_a, num_b, den_b));
            if (pop && !empty)
            begin
                if (fracq.size() == 0)
                begin
                    $display("unexpected result transfer at %0t", $time);
                    errors++;
                end
                else
                begin
                    w = fracq.pop_front();
                    if (res_num !== w.n)
                        report("res_num", res_num, w.n);
                    if (res_den !== w.d)
                        report("res_den", res_den, w.d);
                end
            end
        end
    end
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives directed and random fraction operations with random gaps on both
// queues, a long result stall and a full drain pause; checking is done in
// rau_checker
// ----------------------------------------------------------------------------
module testbench;
    localparam int LIMIT = 3000000;

    logic           clk;
    logic           rst_n;
    logic           push;
    logic           full;
    rau_pkg::mode_t mode;
    rau_pkg::word_t num_a;
    rau_pkg::word_t den_a;
    rau_pkg::word_t num_b;
    rau_pkg::word_t den_b;
    logic           empty;
    logic           pop;
    rau_pkg::word_t res_num;
    rau_pkg::word_t res_den;
    int             errors;
    int             pending;
    int             cycles;
    logic           hold_off;
    logic           stim_done;

    rational_arithmetic_unit_core DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .mode(mode),
        .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
        .empty(empty), .pop(pop), .res_num(res_num), .res_den(res_den)
    );

    rau_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .mode(mode),
        .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
        .empty(empty), .pop(pop), .res_num(res_num), .res_den(res_den),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic rau_pkg::word_t pick_word();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(rau_pkg::WORD_BITS-1){1'b0}}};
            1: return rau_pkg::MAXV;
            2: return 0;
            3: return 1;
            4: return -1;
            5, 6: return rau_pkg::word_t'($urandom_range(0, 40)) - 20;
            7: return rau_pkg::word_t'($urandom_range(0, 2000)) - 1000;
            default: return rau_pkg::word_t'($urandom);
        endcase
    endfunction

    task automatic transfer_item(rau_pkg::mode_t m, rau_pkg::word_t na, rau_pkg::word_t da,
                                 rau_pkg::word_t nb, rau_pkg::word_t db);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        mode  <= m;
        num_a <= na;
        den_a <= da;
        num_b <= nb;
        den_b <= db;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // directed operands: extremes, zero denominators, min by -1
    task automatic run_directed();
        rau_pkg::word_t mn;
        mn = {1'b1, {(rau_pkg::WORD_BITS-1){1'b0}}};
        for (int m = 0; m < 8; m++)
            transfer_item(rau_pkg::mode_t'(m), 6, -4, 3, 9);
        transfer_item(rau_pkg::MODE_ADD, rau_pkg::MAXV, rau_pkg::MAXV, rau_pkg::MAXV,
                      rau_pkg::MAXV);
        transfer_item(rau_pkg::MODE_SUB, mn, mn, mn, mn);
        transfer_item(rau_pkg::MODE_MUL, mn, -1, -1, 1);
        transfer_item(rau_pkg::MODE_DIV, 5, 7, 0, 3);
        transfer_item(rau_pkg::MODE_INV, 0, 5, 0, 0);
        transfer_item(rau_pkg::MODE_INV, -8, 12, 0, 0);
        transfer_item(rau_pkg::MODE_NORM, 7, 0, 0, 0);
        transfer_item(rau_pkg::MODE_NORM, mn, -1, 0, 0);
        transfer_item(rau_pkg::mode_t'(6), -1, -1, -1, -1);
        transfer_item(rau_pkg::mode_t'(7), '1, '1, '1, '1);
        transfer_item(rau_pkg::MODE_ADD, 0, 0, 0, 0);
        transfer_item(rau_pkg::MODE_MUL, mn, mn, rau_pkg::MAXV, mn);
        transfer_item(rau_pkg::MODE_NORM, 10, -4, 0, 0);
        transfer_item(rau_pkg::MODE_DIV, -3, 5, 4, -7);
    endtask

    initial
    begin
        rst_n     = 0;
        push      = 0;
        mode      = '0;
        num_a     = '0;
        den_a     = '0;
        num_b     = '0;
        den_b     = '0;
        hold_off  = 0;
        stim_done = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int i = 0; i < 300; i++)
        begin
            if (i == 60)
                hold_off <= 1'b1;
            if (i == 150)
            begin
                push <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            transfer_item(rau_pkg::mode_t'($urandom_range(0, 7)), pick_word(), pick_word(),
                          pick_word(), pick_word());
        end
        push      <= 1'b0;
        stim_done <= 1'b1;
    end

    // result side with random gaps and one long stall
    initial
    begin
        int gap;
        bit stall_done;
        pop = 0;
        stall_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off && !stall_done)
            begin
                pop <= 1'b0;
                repeat (40000) @(posedge clk);
                stall_done = 1;
            end
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (2500) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
